[hw/rtl/orca_pkg.sv]
package orca_pkg;

  localparam int DEF_TABLE_DEPTH = 8;
  localparam int DEF_ADDR_BITS   = 32;
  localparam int FIELD_W         = 32;
  localparam int COUNT_W         = 4;

  typedef enum logic [2:0] {
    ST_ADMIT         = 3'd0,
    ST_WAIT_ORDER    = 3'd1,
    ST_WAIT_CONFLICT = 3'd2,
    ST_FULL          = 3'd3,
    ST_EXIT_DONE     = 3'd4,
    ST_EXIT_MISS     = 3'd5,
    ST_STALE         = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic walk_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_last;
  } dp_sts_t;

endpackage

[hw/rtl/ordered_range_conflict_admitter.sv]
// Channel | Handshake            | Beat contents
// input   | in_valid / in_stall  | mode, seq_number, whole_object, range_start, range_length
// output  | out_valid / out_stall| status, wake, in_flight
//
// Each beat is handled by a walk over the request table through its single read port
// and one overlap comparator.
// Reset is synchronous and clears the counters, wait marks and valid bits; table contents
// are not cleared and need no clearing pass.
// in_stall is high from acceptance until the result is loaded into the output register.
// A result held by out_stall keeps the block in its final step; a new beat is taken
// while an earlier result still waits.
module ordered_range_conflict_admitter #(
  parameter int TABLE_DEPTH = orca_pkg::DEF_TABLE_DEPTH,
  parameter int ADDR_BITS   = orca_pkg::DEF_ADDR_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         mode,
  input  logic [orca_pkg::FIELD_W-1:0] seq_number,
  input  logic                         whole_object,
  input  logic [orca_pkg::FIELD_W-1:0] range_start,
  input  logic [orca_pkg::FIELD_W-1:0] range_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   status,
  output logic                         wake,
  output logic [orca_pkg::COUNT_W-1:0] in_flight
);

  orca_pkg::dp_cmd_t cmd;
  orca_pkg::dp_sts_t sts;

  orca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  orca_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (mode),
    .seq_number   (seq_number),
    .whole_object (whole_object),
    .range_start  (range_start),
    .range_length (range_length),
    .status       (status),
    .wake         (wake),
    .in_flight    (in_flight)
  );

endmodule

[hw/rtl/orca_ctrl.sv]
module orca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output orca_pkg::dp_cmd_t cmd,
  input  orca_pkg::dp_sts_t sts
);

  orca_pkg::state_t state;
  orca_pkg::state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != orca_pkg::S_IDLE);
    case (state)
      orca_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = orca_pkg::S_WALK;
        end
      end
      orca_pkg::S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          state_next = orca_pkg::S_DONE;
        end
      end
      orca_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.commit = 1'b1;
          state_next = orca_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = orca_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= orca_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result beat not presented after commit");

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == orca_pkg::S_WALK))
    else $error("accepted beat did not start the table walk");

  a_last_only_in_walk: assert property (@(posedge clk) disable iff (rst)
    sts.walk_last |-> (state == orca_pkg::S_WALK))
    else $error("walk end seen outside the walk");

  a_no_commit_over_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.commit)
    else $error("commit overwrote a stalled result");

endmodule

[hw/rtl/orca_dpath.sv]
module orca_dpath #(
  parameter int TABLE_DEPTH = orca_pkg::DEF_TABLE_DEPTH,
  parameter int ADDR_BITS   = orca_pkg::DEF_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  orca_pkg::dp_cmd_t             cmd,
  output orca_pkg::dp_sts_t             sts,
  input  logic                          mode,
  input  logic [orca_pkg::FIELD_W-1:0]  seq_number,
  input  logic                          whole_object,
  input  logic [orca_pkg::FIELD_W-1:0]  range_start,
  input  logic [orca_pkg::FIELD_W-1:0]  range_length,
  output logic [2:0]                    status,
  output logic                          wake,
  output logic [orca_pkg::COUNT_W-1:0]  in_flight
);

  localparam int SW = orca_pkg::FIELD_W;
  localparam int AW = (ADDR_BITS < orca_pkg::FIELD_W) ? ADDR_BITS : orca_pkg::FIELD_W;
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_DEPTH - 1);

  // Table contents; valid bits live in flops, the rest in memory.
  logic [SW-1:0] mem_seq   [TABLE_DEPTH];
  logic          mem_glb   [TABLE_DEPTH];
  logic [AW-1:0] mem_start [TABLE_DEPTH];
  logic [AW-1:0] mem_len   [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] valid_next;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [SW-1:0]          next_arrival;
  logic [SW-1:0]          next_arrival_next;
  logic [SW-1:0]          next_completion;
  logic [SW-1:0]          next_completion_next;
  logic                   order_mark;
  logic                   order_mark_next;
  logic                   conflict_mark;
  logic                   conflict_mark_next;

  logic          req_exit;
  logic [SW-1:0] req_seq;
  logic          req_whole;
  logic [AW-1:0] req_start;
  logic [AW-1:0] req_len;
  logic [AW:0]   req_end;

  logic [CW-1:0] rd_ptr;
  logic          chk_vld;
  logic [IW-1:0] chk_idx;
  logic [SW-1:0] rd_seq;
  logic          rd_glb;
  logic [AW-1:0] rd_start;
  logic [AW-1:0] rd_len;

  logic          conf_acc;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          match_found;
  logic [IW-1:0] match_idx;

  logic          chk_live;
  logic [AW:0]   chk_end;
  logic          chk_hit;
  logic [SW-1:0] diff;
  orca_pkg::status_t res_status;
  logic          res_wake;
  logic          do_admit;
  logic [CW+orca_pkg::COUNT_W-1:0] count_ext;

  orca_pkg::status_t status_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_exit  <= mode;
      req_seq   <= seq_number;
      req_whole <= whole_object;
      req_start <= range_start[AW-1:0];
      req_len   <= range_length[AW-1:0];
      req_end   <= {1'b0, range_start[AW-1:0]} + {1'b0, range_length[AW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step && rd_ptr != DEPTH_CNT) begin
      rd_seq   <= mem_seq[rd_ptr[IW-1:0]];
      rd_glb   <= mem_glb[rd_ptr[IW-1:0]];
      rd_start <= mem_start[rd_ptr[IW-1:0]];
      rd_len   <= mem_len[rd_ptr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (do_admit && cmd.commit) begin
      mem_seq[free_idx]   <= req_seq;
      mem_glb[free_idx]   <= req_whole;
      mem_start[free_idx] <= req_start;
      mem_len[free_idx]   <= req_len;
    end
  end

  assign chk_live = valid[chk_idx];
  assign chk_end  = {1'b0, rd_start} + {1'b0, rd_len};
  assign chk_hit  = rd_glb
                 || ((rd_start <= req_start) && (chk_end > {1'b0, req_start}))
                 || ((rd_start > req_start) && ({1'b0, rd_start} < req_end));
  assign sts.walk_last = chk_vld && (chk_idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr      <= '0;
      chk_vld     <= 1'b0;
      conf_acc    <= 1'b0;
      free_found  <= 1'b0;
      match_found <= 1'b0;
    end else if (cmd.load) begin
      rd_ptr      <= '0;
      chk_vld     <= 1'b0;
      conf_acc    <= 1'b0;
      free_found  <= 1'b0;
      match_found <= 1'b0;
    end else begin
      chk_vld <= cmd.walk_step && (rd_ptr != DEPTH_CNT);
      if (cmd.walk_step && rd_ptr != DEPTH_CNT) begin
        chk_idx <= rd_ptr[IW-1:0];
        rd_ptr  <= rd_ptr + CW'(1);
      end
      if (chk_vld) begin
        if (chk_live && chk_hit) begin
          conf_acc <= 1'b1;
        end
        if (!chk_live && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= chk_idx;
        end
        if (chk_live && rd_seq == req_seq && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= chk_idx;
        end
      end
    end
  end

  assign diff = req_seq - next_arrival;

  always_comb begin
    res_status           = orca_pkg::ST_EXIT_MISS;
    res_wake             = 1'b0;
    do_admit             = 1'b0;
    valid_next           = valid;
    count_next           = count;
    next_arrival_next    = next_arrival;
    next_completion_next = next_completion;
    order_mark_next      = order_mark;
    conflict_mark_next   = conflict_mark;
    if (!req_exit) begin
      if (diff != '0) begin
        if (diff[SW-1]) begin
          res_status = orca_pkg::ST_STALE;
        end else begin
          res_status      = orca_pkg::ST_WAIT_ORDER;
          order_mark_next = 1'b1;
        end
      end else if ((req_whole || conf_acc) && req_seq != next_completion) begin
        res_status         = orca_pkg::ST_WAIT_CONFLICT;
        conflict_mark_next = 1'b1;
      end else if (!free_found) begin
        res_status = orca_pkg::ST_FULL;
      end else begin
        res_status           = orca_pkg::ST_ADMIT;
        do_admit             = 1'b1;
        valid_next[free_idx] = 1'b1;
        count_next           = count + CW'(1);
        next_arrival_next    = next_arrival + SW'(1);
        res_wake             = order_mark;
        order_mark_next      = 1'b0;
      end
    end else if (match_found) begin
      res_status            = orca_pkg::ST_EXIT_DONE;
      valid_next[match_idx] = 1'b0;
      count_next            = count - CW'(1);
      next_completion_next  = next_completion + SW'(1);
      res_wake              = conflict_mark;
      conflict_mark_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= '0;
      count           <= '0;
      next_arrival    <= '0;
      next_completion <= '0;
      order_mark      <= 1'b0;
      conflict_mark   <= 1'b0;
    end else if (cmd.commit) begin
      valid           <= valid_next;
      count           <= count_next;
      next_arrival    <= next_arrival_next;
      next_completion <= next_completion_next;
      order_mark      <= order_mark_next;
      conflict_mark   <= conflict_mark_next;
    end
  end

  assign count_ext = {{orca_pkg::COUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_q  <= res_status;
      wake      <= res_wake;
      in_flight <= count_ext[orca_pkg::COUNT_W-1:0];
    end
  end

  assign status = status_q;

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    count == CW'($countones(valid)))
    else $error("occupancy count disagrees with valid bits");

  a_admit_grows_table: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && res_status == orca_pkg::ST_ADMIT) |=> count == $past(count) + CW'(1))
    else $error("admitted request did not take a table entry");

  a_wake_source: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && res_wake)
      |-> (res_status == orca_pkg::ST_ADMIT || res_status == orca_pkg::ST_EXIT_DONE))
    else $error("wake raised without admission or completion");

endmodule
